>>> src/rpn_pkg.sv
// Shared types and constants for the RPN stack evaluator.
package rpn_pkg;

   localparam logic [2:0] OP_PUSH   = 3'd0;
   localparam logic [2:0] OP_ADD    = 3'd1;
   localparam logic [2:0] OP_SUB    = 3'd2;
   localparam logic [2:0] OP_MUL    = 3'd3;
   localparam logic [2:0] OP_DIV    = 3'd4;
   localparam logic [2:0] OP_BAD    = 3'd5;
   localparam logic [2:0] OP_END    = 3'd6;
   localparam logic [2:0] OP_SPARE  = 3'd7;  // unassigned code, handled as invalid

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] number_value;
   } req_type;

   typedef struct packed {
      logic signed [63:0] result_value;
      logic [1:0]         empty_pop_count;
      logic               stack_full_flag;
      logic               divide_by_zero_flag;
      logic               unknown_operator_flag;
   } rsp_type;

endpackage

>>> src/rpn_mul.sv
// 64-bit wrapping multiplier built from 32x32 partial products computed in sequence.
module rpn_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] product
);
   logic [1:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] x, y;
   logic [63:0] pp_ff;
   logic        pv_ff;

   // choose partial product operands by step
   always_comb begin
      unique case (step_ff)
         2'd0:    begin x = a[31:0];  y = b[31:0];  end
         2'd1:    begin x = a[63:32]; y = b[31:0];  end
         default: begin x = a[31:0];  y = b[63:32]; end
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 2'd0;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (step_ff != 2'd3) step_in = step_ff + 2'd1;
         else busy_in = 1'b0;
      end
      // accumulate the registered partial product of the previous step
      if (!start && pv_ff) begin
         if (step_ff == 2'd1) acc_in = acc_ff + pp_ff;
         else acc_in = acc_ff + {pp_ff[31:0], 32'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         pv_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         pv_ff   <= busy_ff && !start && step_ff != 2'd3;
      end
      acc_ff <= acc_in;
      pp_ff  <= 64'(x) * 64'(y);
   end

   assign done    = busy_ff && step_ff == 2'd3;
   assign product = acc_in;
endmodule

>>> src/rpn_div.sv
// Iterative signed 64-bit divider, one quotient bit per cycle, truncating toward zero.
module rpn_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] quotient
);
   logic        busy_ff, busy_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic        neg_ff, neg_in;
   logic [64:0] trial;

   assign trial = {r_ff, q_ff[63]} - {1'b0, d_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 7'd0;
         q_in    = a[63] ? (64'd0 - a) : a;
         d_in    = b[63] ? (64'd0 - b) : b;
         r_in    = '0;
         neg_in  = a[63] ^ b[63];
      end else if (busy_ff && cnt_ff != 7'd64) begin
         // restoring step: shift in dividend bit, subtract when it fits
         if (!trial[64]) r_in = trial[63:0];
         else r_in = {r_ff[62:0], q_ff[63]};
         q_in   = {q_ff[62:0], !trial[64]};
         cnt_in = cnt_ff + 7'd1;
      end else if (busy_ff) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
   end

   assign done     = busy_ff && cnt_ff == 7'd64;
   assign quotient = neg_ff ? (64'd0 - q_ff) : q_ff;
endmodule

>>> src/rpn_stack_evaluator.sv
// Top level: token sequencer around the operand stack memory and arithmetic units.
// Each token gives one result. Push writes the stack unless it is full, end pops it,
// and an invalid token goes straight to its result. Add and subtract make two reads
// of the registered stack memory, multiply waits on the partial-product steps of the
// multiplier, and divide on the bit-serial divider; a divide that pops a zero divisor,
// or pops an empty stack for it, skips the divider. The top of stack lives in the stack
// memory; the depth counter is a register cleared at reset. The result sits in an
// output register; the next token is taken the cycle after that result has transferred.
module rpn_stack_evaluator #(
   parameter int STACK_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rpn_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rpn_pkg::rsp_type  rsp_data
);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam logic [DW-1:0] DMAX = DW'(STACK_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_RD_R, S_RD_L, S_EXEC, S_WAIT, S_WB, S_RSP
   } state_type;

   state_type        state_ff;
   logic [DW-1:0]    depth_ff;
   logic [2:0]       op_ff;
   logic [63:0]      num_ff, r_ff, l_ff, res_ff;
   logic [63:0]      l_in;
   logic [1:0]       epop_ff;
   logic             full_ff, divz_ff, unk_ff, rvalid_ff;
   rpn_pkg::rsp_type rsp_ff;

   // stack memory
   logic [63:0]   mem [STACK_DEPTH];
   logic [AW-1:0] raddr, waddr;
   logic          we;
   logic [63:0]   wdata, rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   // left operand as read in S_EXEC; zero when its pop found the stack empty
   assign l_in = ((depth_ff == '0 && epop_ff == 2'd1) || epop_ff == 2'd2) ?
                 64'd0 : rdata_ff;

   logic        mul_start, mul_done, div_start, div_done;
   logic [63:0] mul_p, div_q;

   rpn_mul u_mul (.clock, .reset, .start(mul_start), .a(l_ff), .b(r_ff),
                  .done(mul_done), .product(mul_p));
   rpn_div u_div (.clock, .reset, .start(div_start), .a(l_in), .b(r_ff),
                  .done(div_done), .quotient(div_q));

   logic is_bin;
   assign is_bin = op_ff == rpn_pkg::OP_ADD || op_ff == rpn_pkg::OP_SUB ||
                   op_ff == rpn_pkg::OP_MUL || op_ff == rpn_pkg::OP_DIV;

   assign raddr     = AW'(depth_ff - DW'(1));
   assign req_ready = state_ff == S_IDLE && !rvalid_ff;
   assign rsp_valid = rvalid_ff;
   assign rsp_data  = rsp_ff;
   assign mul_start = state_ff == S_EXEC && op_ff == rpn_pkg::OP_MUL;
   assign div_start = state_ff == S_EXEC && op_ff == rpn_pkg::OP_DIV;

   // write port: push number or operator result
   always_comb begin
      we    = 1'b0;
      waddr = AW'(depth_ff);
      wdata = (op_ff == rpn_pkg::OP_PUSH) ? num_ff : res_ff;
      if (state_ff == S_WB && depth_ff != DMAX) we = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         depth_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (rvalid_ff && rsp_ready) rvalid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  op_ff   <= req_data.operation;
                  num_ff  <= 64'(req_data.number_value);
                  epop_ff <= '0;
                  full_ff <= 1'b0;
                  divz_ff <= 1'b0;
                  unk_ff  <= 1'b0;
                  r_ff    <= '0;
                  l_ff    <= '0;
                  res_ff  <= '0;
                  state_ff <= S_RD_R;
               end
            end
            // memory read of top issued; pop it for operators and end
            S_RD_R: begin
               priority if (op_ff == rpn_pkg::OP_PUSH) begin
                  state_ff <= S_WB;
               end else if (is_bin || op_ff == rpn_pkg::OP_END) begin
                  if (depth_ff == '0) epop_ff <= 2'd1;
                  else depth_ff <= depth_ff - DW'(1);
                  state_ff <= S_RD_L;
               end else begin
                  unk_ff   <= 1'b1;
                  state_ff <= S_RSP;
               end
            end
            // right operand available; second read issued at new top
            S_RD_L: begin
               priority if (op_ff == rpn_pkg::OP_END) begin
                  res_ff   <= (epop_ff == '0) ? rdata_ff : 64'd0;
                  state_ff <= S_RSP;
               end else begin
                  r_ff <= (epop_ff == '0) ? rdata_ff : 64'd0;
                  if (op_ff == rpn_pkg::OP_DIV &&
                      (epop_ff != '0 || rdata_ff == 64'd0)) begin
                     divz_ff  <= 1'b1;
                     state_ff <= S_RSP;
                  end else begin
                     if (depth_ff == '0) epop_ff <= epop_ff + 2'd1;
                     else depth_ff <= depth_ff - DW'(1);
                     state_ff <= S_EXEC;
                  end
               end
            end
            S_EXEC: begin
               l_ff     <= l_in;
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               unique case (op_ff)
                  rpn_pkg::OP_ADD: begin res_ff <= l_ff + r_ff; state_ff <= S_WB; end
                  rpn_pkg::OP_SUB: begin res_ff <= l_ff - r_ff; state_ff <= S_WB; end
                  rpn_pkg::OP_MUL: if (mul_done) begin
                     res_ff <= mul_p; state_ff <= S_WB;
                  end
                  default: if (div_done) begin
                     res_ff <= div_q; state_ff <= S_WB;
                  end
               endcase
            end
            S_WB: begin
               if (depth_ff == DMAX) full_ff <= 1'b1;
               else depth_ff <= depth_ff + DW'(1);
               if (op_ff != rpn_pkg::OP_PUSH) res_ff <= '0;
               state_ff <= S_RSP;
            end
            default: begin
               rsp_ff.result_value          <= res_ff;
               rsp_ff.empty_pop_count       <= epop_ff;
               rsp_ff.stack_full_flag       <= full_ff;
               rsp_ff.divide_by_zero_flag   <= divz_ff;
               rsp_ff.unknown_operator_flag <= unk_ff;
               rvalid_ff <= 1'b1;
               state_ff  <= S_IDLE;
            end
         endcase
      end
   end
endmodule

>>> bench/rpn_checker.sv
// Checker for the RPN evaluator: predicts each result from accepted tokens and compares.
module rpn_checker #(
   parameter int STACK_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  rpn_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rpn_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count
);
   logic [63:0]      calc_stack [STACK_DEPTH];
   int               calc_depth;
   rpn_pkg::rsp_type expected_rsps [$];

   assign pending_count = expected_rsps.size();

   // Pop one operand; an empty stack gives zero and bumps the empty count.
   function automatic logic [63:0] calc_pop(inout logic [1:0] empties);
      if (calc_depth > 0) begin
         calc_depth--;
         return calc_stack[calc_depth];
      end
      empties++;
      return 64'd0;
   endfunction

   function automatic logic calc_push(input logic [63:0] v);
      if (calc_depth >= STACK_DEPTH) return 1'b1;
      calc_stack[calc_depth] = v;
      calc_depth++;
      return 1'b0;
   endfunction

   // Truncating signed divide; min / -1 wraps back to min.
   function automatic logic [63:0] div_toward_zero(input logic [63:0] a,
                                                   input logic [63:0] b);
      logic [63:0] ua;
      logic [63:0] ub;
      logic [63:0] q;
      ua = a[63] ? -a : a;
      ub = b[63] ? -b : b;
      q  = ua / ub;
      return (a[63] != b[63]) ? -q : q;
   endfunction

   function automatic rpn_pkg::rsp_type evaluate_token(input rpn_pkg::req_type tok);
      rpn_pkg::rsp_type r;
      logic [63:0]      lhs;
      logic [63:0]      rhs;
      logic [63:0]      num;
      logic [1:0]       empties;
      r       = '0;
      empties = '0;
      num     = {{32{tok.number_value[31]}}, tok.number_value};
      case (tok.operation)
         rpn_pkg::OP_PUSH: r.stack_full_flag = calc_push(num);
         rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL: begin
            rhs = calc_pop(empties);
            lhs = calc_pop(empties);
            if (tok.operation == rpn_pkg::OP_ADD)
               r.stack_full_flag = calc_push(lhs + rhs);
            else if (tok.operation == rpn_pkg::OP_SUB)
               r.stack_full_flag = calc_push(lhs - rhs);
            else
               r.stack_full_flag = calc_push(lhs * rhs);
         end
         rpn_pkg::OP_DIV: begin
            rhs = calc_pop(empties);
            if (rhs == 64'd0) begin
               r.divide_by_zero_flag = 1'b1;
            end else begin
               lhs = calc_pop(empties);
               r.stack_full_flag = calc_push(div_toward_zero(lhs, rhs));
            end
         end
         rpn_pkg::OP_END: r.result_value = calc_pop(empties);
         default: r.unknown_operator_flag = 1'b1;
      endcase
      r.empty_pop_count = empties;
      return r;
   endfunction

   // Predict on each input transfer, compare on each result transfer.
   always @(posedge clock) begin
      rpn_pkg::rsp_type want;
      if (reset) begin
         calc_depth = 0;
         expected_rsps.delete();
         fail_count = 0;
      end else begin
         if (req_valid && req_ready)
            expected_rsps.push_back(evaluate_token(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("ERROR: unexpected result %h", rsp_data);
            end else begin
               want = expected_rsps.pop_front();
               if (want != rsp_data) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"ERROR: value exp %h got %h, empty exp %0d got %0d, ",
                               "full exp %b got %b, divz exp %b got %b, ",
                               "unk exp %b got %b"},
                        want.result_value, rsp_data.result_value,
                        want.empty_pop_count, rsp_data.empty_pop_count,
                        want.stack_full_flag, rsp_data.stack_full_flag,
                        want.divide_by_zero_flag, rsp_data.divide_by_zero_flag,
                        want.unknown_operator_flag, rsp_data.unknown_operator_flag);
               end
            end
         end
      end
   end
endmodule

>>> bench/tb_top.sv
// Testbench top for the RPN evaluator: token stimulus, result stalls and verdict.
module tb_top;
   localparam int DEPTH     = 32;
   localparam int IDLE_MAX  = 20000;
   localparam int RAND_TOKS = 1750;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   rpn_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rpn_pkg::rsp_type rsp_data;
   int               fail_count;
   int               pending_count;
   int               idle_cycles = 0;
   bit               long_hold = 1'b0;
   bit               hold_done = 1'b0;
   int               gap_left = 0;

   always #1 clock = ~clock;

   rpn_stack_evaluator #(.STACK_DEPTH(DEPTH)) u_top (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   rpn_checker #(.STACK_DEPTH(DEPTH)) u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .fail_count, .pending_count
   );

   // Watchdog on cycles with no transfer.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver: its own stall pattern, plus one long hold-off on request.
   always @(posedge clock) begin
      int hold;
      if (long_hold && !hold_done) begin
         rsp_ready <= 1'b0;
         for (hold = 0; hold < 300; hold++) @(posedge clock);
         hold_done = 1'b1;
      end else if (gap_left > 0) begin
         rsp_ready <= 1'b0;
         gap_left  <= gap_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 15) == 0) gap_left <= $urandom_range(1, 12);
      end
   end

   // Send one token; valid stays up until the transfer and is left up for the next.
   task automatic send_token(input logic [2:0] op, input logic [31:0] num);
      req_valid <= 1'b1;
      req_data  <= '{operation: op, number_value: num};
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and idle for a span set by n (n at least 1).
   task automatic pause_sender(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Stop sending until every expected result has come back.
   task automatic wait_drained();
      pause_sender(1);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_number();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'(int'($urandom_range(0, 6)) - 3);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [2:0] rand_operator();
      case ($urandom_range(0, 9))
         0, 1: return rpn_pkg::OP_ADD;
         2, 3: return rpn_pkg::OP_SUB;
         4, 5: return rpn_pkg::OP_MUL;
         6, 7: return rpn_pkg::OP_DIV;
         8:    return rpn_pkg::OP_END;
         default: return ($urandom_range(0, 1) != 0) ? rpn_pkg::OP_BAD : rpn_pkg::OP_SPARE;
      endcase
   endfunction

   initial begin
      int depth;
      int burst;
      int sent;
      int k;
      int gap;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-stack ops, extremes, wrapping multiply, negative divide, zero divide, codes 5 and 7.
      send_token(rpn_pkg::OP_ADD, 32'd0);
      send_token(rpn_pkg::OP_END, 32'd0);
      send_token(rpn_pkg::OP_DIV, 32'hffff_ffff);
      send_token(rpn_pkg::OP_PUSH, 32'h8000_0000);
      send_token(rpn_pkg::OP_PUSH, 32'h8000_0000);
      send_token(rpn_pkg::OP_MUL, 32'd0);
      send_token(rpn_pkg::OP_PUSH, 32'hffff_ffff);
      send_token(rpn_pkg::OP_PUSH, 32'h8000_0000);
      send_token(rpn_pkg::OP_MUL, 32'd0);
      send_token(rpn_pkg::OP_MUL, 32'd0);
      send_token(rpn_pkg::OP_PUSH, 32'hffff_ffff);
      send_token(rpn_pkg::OP_DIV, 32'd0);
      send_token(rpn_pkg::OP_PUSH, 32'h7fff_ffff);
      send_token(rpn_pkg::OP_PUSH, 32'd0);
      send_token(rpn_pkg::OP_DIV, 32'd0);
      send_token(rpn_pkg::OP_PUSH, 32'hffff_fff9);
      send_token(rpn_pkg::OP_DIV, 32'd0);
      send_token(rpn_pkg::OP_SUB, 32'd5);
      send_token(rpn_pkg::OP_BAD, 32'd1);
      send_token(rpn_pkg::OP_SPARE, 32'd2);
      send_token(rpn_pkg::OP_END, 32'd0);
      send_token(rpn_pkg::OP_END, 32'd0);
      // Fill past the top to hit the full-stack drop.
      for (k = 0; k < DEPTH + 2; k++) send_token(rpn_pkg::OP_PUSH, $urandom());
      send_token(rpn_pkg::OP_ADD, 32'd0);
      wait_drained();

      // Random: well-formed expressions with some noise, sent in bursts.
      sent  = 0;
      depth = 0;
      while (sent < RAND_TOKS) begin
         burst = $urandom_range(1, 30);
         for (k = 0; k < burst; k++) begin
            if (sent >= 600) long_hold = 1'b1;
            if ($urandom_range(0, 19) == 0) begin
               send_token(3'($urandom_range(0, 7)), $urandom());
            end else if (depth < 2 || ($urandom_range(0, 2) == 0 && depth < DEPTH)) begin
               send_token(rpn_pkg::OP_PUSH, rand_number());
               depth++;
            end else begin
               send_token(rand_operator(), $urandom());
               if ($urandom_range(0, 3) == 0) depth = 0;
               else depth--;
            end
            sent++;
            if (sent == 1200) wait_drained();
         end
         gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) pause_sender(gap);
         if ($urandom_range(0, 15) == 0) begin
            // Drain the stack so the checker-tracked depth matches ours again.
            for (k = 0; k < DEPTH + 1; k++) send_token(rpn_pkg::OP_END, $urandom());
            depth = 0;
            sent += DEPTH + 1;
         end
      end

      wait_drained();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule

>>> sim.f
src/rpn_pkg.sv
src/rpn_mul.sv
src/rpn_div.sv
src/rpn_stack_evaluator.sv
bench/rpn_checker.sv
bench/tb_top.sv
